/* rtl/core/hlt_pkg.sv */
`timescale 1ns / 1ps

package hlt_pkg;

    localparam int MAX_PEERS_DEF   = 32;
    localparam logic [7:0] RESET_COUNTDOWN = 8'd10;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD  = 1'd1;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_HB   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    typedef struct packed {
        logic [7:0]  subsystem;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  countdown;
        logic        up;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic add;
        logic hb;
        logic tick;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
    } dp_status_t;

endpackage

/* rtl/core/heartbeat_liveness_table.sv */
`timescale 1ns / 1ps
// Channel   | Handshake                 | Beat
// ----------+---------------------------+---------------------------------------------
// command   | start & !busy             | command, subsystem_id, peer_addr, peer_port
// result    | result_valid (one cycle)  | out_* fields, flags, last_result
// config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// Add: load, then write. Heartbeat: load, then scan to the matching entry (whole table on a miss).
// Tick: load, then every entry in turn; one entry per cycle through the table
// (registered read, evaluate, write back). A result strobes in the cycle after its entry
// is evaluated. Reset clears the fill count and control; table contents need no clear.
// The receiver cannot stall: results are never held off. cfg_ready is always high.

module heartbeat_liveness_table
    import hlt_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [7:0]           subsystem_id,
    input  logic [31:0]          peer_addr,
    input  logic [15:0]          peer_port,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 result_valid,
    output logic [7:0]           out_subsystem,
    output logic [31:0]          out_addr,
    output logic [15:0]          out_port,
    output logic                 send_keepalive,
    output logic                 state_changed,
    output logic                 now_connected,
    output logic                 table_full,
    output logic                 last_result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    hlt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    hlt_dpath #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .subsystem_id   (subsystem_id),
        .peer_addr      (peer_addr),
        .peer_port      (peer_port),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .out_subsystem  (out_subsystem),
        .out_addr       (out_addr),
        .out_port       (out_port),
        .send_keepalive (send_keepalive),
        .state_changed  (state_changed),
        .now_connected  (now_connected),
        .table_full     (table_full),
        .last_result    (last_result)
    );

`ifndef SYNTHESIS
    // an add always answers: acceptance, then S_ADD, then the registered result
    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_ADD) |-> ##2 result_valid)
        else $error("add beat produced no result");

    // tick changes only take an entry down, heartbeat changes only bring it up
    a_change_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && state_changed) |-> (now_connected != send_keepalive))
        else $error("state change in wrong direction");

    a_full_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && table_full) |-> (last_result && !now_connected && !send_keepalive))
        else $error("refused add result malformed");

    // a result with last set ends the operation: nothing follows without a new beat
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result && !busy) |=> !result_valid)
        else $error("result after last");
`endif

endmodule

/* rtl/core/hlt_ctrl.sv */
`timescale 1ns / 1ps

module hlt_ctrl
    import hlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_HB   = 4'b0100,
        S_TICK = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (command)
                        CMD_ADD:  state_next = S_ADD;
                        CMD_HB:   state_next = status.empty ? S_IDLE : S_HB;
                        CMD_TICK: state_next = status.empty ? S_IDLE : S_TICK;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_IDLE;
            end
            S_HB:
            begin
                cmd.hb = 1'b1;
                if (status.hit || status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                cmd.tick = 1'b1;
                if (status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/hlt_dpath.sv */
`timescale 1ns / 1ps

module hlt_dpath
    import hlt_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [7:0]           subsystem_id,
    input  logic [31:0]          peer_addr,
    input  logic [15:0]          peer_port,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 result_valid,
    output logic [7:0]           out_subsystem,
    output logic [31:0]          out_addr,
    output logic [15:0]          out_port,
    output logic                 send_keepalive,
    output logic                 state_changed,
    output logic                 now_connected,
    output logic                 table_full,
    output logic                 last_result
);

    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W = $clog2(MAX_PEERS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PEERS);

    entry_t mem [MAX_PEERS];
    entry_t rd_data_reg;

    logic [7:0]       init_cd_reg, reload_reg;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       sub_reg;
    logic [31:0]      addr_reg;
    logic [15:0]      port_reg;

    logic             full, hit, last;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data, cur, ticked;
    logic             tick_changed;

    logic             res_valid_next;
    entry_t           res_entry;
    logic             res_keep, res_changed, res_conn, res_full, res_last;

    assign cur  = rd_data_reg;
    assign full = (total_reg == FULL_CNT);
    assign hit  = (cur.addr == addr_reg) && (cur.port == port_reg);
    assign last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == total_reg);

    assign status.empty = (total_reg == '0);
    assign status.last  = last;
    assign status.hit   = hit;

    // tick update of the entry under the pointer
    always_comb
    begin
        ticked       = cur;
        tick_changed = 1'b0;
        if (cur.countdown != 8'd0)
        begin
            ticked.countdown = cur.countdown - 8'd1;
        end
        else if (cur.up)
        begin
            ticked.up    = 1'b0;
            tick_changed = 1'b1;
        end
    end

    always_comb
    begin
        we             = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = cur;
        ptr_next       = ptr_reg;
        total_next     = total_reg;
        res_valid_next = 1'b0;
        res_entry      = cur;
        res_keep       = 1'b0;
        res_changed    = 1'b0;
        res_conn       = 1'b0;
        res_full       = 1'b0;
        res_last       = 1'b1;

        if (cmd.load)
        begin
            ptr_next = '0;
        end

        if (cmd.add)
        begin
            res_valid_next      = 1'b1;
            res_entry.subsystem = sub_reg;
            res_entry.addr      = addr_reg;
            res_entry.port      = port_reg;
            if (full)
            begin
                res_full = 1'b1;
            end
            else
            begin
                we                = 1'b1;
                wr_addr           = total_reg[IDX_W-1:0];
                wr_data.subsystem = sub_reg;
                wr_data.addr      = addr_reg;
                wr_data.port      = port_reg;
                wr_data.countdown = init_cd_reg;
                wr_data.up        = 1'b1;
                total_next        = total_reg + CNT_W'(1);
                res_conn          = 1'b1;
            end
        end

        if (cmd.hb)
        begin
            if (hit)
            begin
                we                = 1'b1;
                wr_data.countdown = reload_reg;
                wr_data.up        = 1'b1;
                res_valid_next    = !cur.up;
                res_changed       = 1'b1;
                res_conn          = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + IDX_W'(1);
            end
        end

        if (cmd.tick)
        begin
            we             = 1'b1;
            wr_data        = ticked;
            ptr_next       = ptr_reg + IDX_W'(1);
            res_valid_next = 1'b1;
            res_keep       = 1'b1;
            res_changed    = tick_changed;
            res_conn       = ticked.up;
            res_last       = last;
        end
    end

    // registered read at the next pointer, write back at the current one (an add writes at the fill count)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            ptr_reg      <= '0;
            init_cd_reg  <= RESET_COUNTDOWN;
            reload_reg   <= RESET_COUNTDOWN;
            result_valid <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            ptr_reg      <= ptr_next;
            result_valid <= res_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_INITIAL)
                begin
                    init_cd_reg <= cfg_data;
                end
                else if (cfg_index == CFG_RELOAD)
                begin
                    reload_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg  <= subsystem_id;
            addr_reg <= peer_addr;
            port_reg <= peer_port;
        end
        out_subsystem  <= res_entry.subsystem;
        out_addr       <= res_entry.addr;
        out_port       <= res_entry.port;
        send_keepalive <= res_keep;
        state_changed  <= res_changed;
        now_connected  <= res_conn;
        table_full     <= res_full;
        last_result    <= res_last;
    end

endmodule

/* tb/sv/heartbeat_liveness_table_tb.sv */
`timescale 1ns / 1ps

module heartbeat_liveness_table_tb
    import hlt_pkg::*;
();

    localparam int         PEERS          = MAX_PEERS_DEF;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    // longest quiet stretch in a good run: a heartbeat miss plus the settle wait plus a gap
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [7:0]  sub;
        logic [31:0] addr;
        logic [15:0] port;
        logic        keep;
        logic        changed;
        logic        conn;
        logic        full;
        logic        last;
    } liveness_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           command;
    logic [7:0]           subsystem_id;
    logic [31:0]          peer_addr;
    logic [15:0]          peer_port;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 result_valid;
    logic [7:0]           out_subsystem;
    logic [31:0]          out_addr;
    logic [15:0]          out_port;
    logic                 send_keepalive;
    logic                 state_changed;
    logic                 now_connected;
    logic                 table_full;
    logic                 last_result;

    // shadow copy of the peer table and registers
    logic [7:0]  tbl_sub  [PEERS];
    logic [31:0] tbl_addr [PEERS];
    logic [15:0] tbl_port [PEERS];
    logic [7:0]  tbl_cd   [PEERS];
    logic        tbl_up   [PEERS];
    int          tbl_count;
    logic [7:0]  cur_initial;
    logic [7:0]  cur_reload;

    liveness_report_t expected_reports[$];
    int               fail_count;
    int               quiet_cycles;
    bit               idle_enable;

    heartbeat_liveness_table u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .subsystem_id   (subsystem_id),
        .peer_addr      (peer_addr),
        .peer_port      (peer_port),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .out_subsystem  (out_subsystem),
        .out_addr       (out_addr),
        .out_port       (out_port),
        .send_keepalive (send_keepalive),
        .state_changed  (state_changed),
        .now_connected  (now_connected),
        .table_full     (table_full),
        .last_result    (last_result)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic predict_liveness(input logic [1:0] cmd, input logic [7:0] sub,
                                    input logic [31:0] addr, input logic [15:0] port);
        liveness_report_t rpt;
        bit               found;
        logic             changed;
        found = 1'b0;
        if (cmd == CMD_ADD)
        begin
            if (tbl_count >= PEERS)
            begin
                rpt = '{sub, addr, port, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
                expected_reports = {expected_reports, rpt};
            end
            else
            begin
                tbl_sub[tbl_count]  = sub;
                tbl_addr[tbl_count] = addr;
                tbl_port[tbl_count] = port;
                tbl_cd[tbl_count]   = cur_initial;
                tbl_up[tbl_count]   = 1'b1;
                tbl_count++;
                rpt = '{sub, addr, port, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
                expected_reports = {expected_reports, rpt};
            end
        end
        else if (cmd == CMD_HB)
        begin
            // only the first matching entry is reloaded
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!found && tbl_addr[i] == addr && tbl_port[i] == port)
                begin
                    found     = 1'b1;
                    tbl_cd[i] = cur_reload;
                    if (!tbl_up[i])
                    begin
                        tbl_up[i] = 1'b1;
                        rpt = '{tbl_sub[i], tbl_addr[i], tbl_port[i],
                                1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
                        expected_reports = {expected_reports, rpt};
                    end
                end
            end
        end
        else if (cmd == CMD_TICK)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                changed = 1'b0;
                if (tbl_cd[i] != 8'd0)
                    tbl_cd[i] = tbl_cd[i] - 8'd1;
                else if (tbl_up[i])
                begin
                    tbl_up[i] = 1'b0;
                    changed   = 1'b1;
                end
                rpt = '{tbl_sub[i], tbl_addr[i], tbl_port[i], 1'b1, changed, tbl_up[i],
                        1'b0, (i == tbl_count - 1)};
                expected_reports = {expected_reports, rpt};
            end
        end
    endtask

    // call at a clock edge; returns at the edge that accepts the beat, start left high
    task automatic issue_command(input logic [1:0] cmd, input logic [7:0] sub,
                                 input logic [31:0] addr, input logic [15:0] port);
        start        <= 1'b1;
        command      <= cmd;
        subsystem_id <= sub;
        peer_addr    <= addr;
        peer_port    <= port;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_liveness(cmd, sub, addr, port);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // drop start, let every expected report arrive, then let a silent heartbeat finish
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] initial_cd, input logic [7:0] reload_cd);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INITIAL;
        cfg_data  <= initial_cd;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_initial = initial_cd;
        cfg_index <= CFG_RELOAD;
        cfg_data  <= reload_cd;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_reload = reload_cd;
        cfg_valid <= 1'b0;
    endtask

    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        liveness_report_t want;
        if (result_valid === 1'b1)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report: expected none, actual sub %0h addr %0h port %0h",
                         $time, out_subsystem, out_addr, out_port);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("out_subsystem", 32'(want.sub), 32'(out_subsystem));
                check_field("out_addr", want.addr, out_addr);
                check_field("out_port", 32'(want.port), 32'(out_port));
                check_field("send_keepalive", 32'(want.keep), 32'(send_keepalive));
                check_field("state_changed", 32'(want.changed), 32'(state_changed));
                check_field("now_connected", 32'(want.conn), 32'(now_connected));
                check_field("table_full", 32'(want.full), 32'(table_full));
                check_field("last_result", 32'(want.last), 32'(last_result));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("heartbeat_liveness_table regression: fail");
            $finish;
        end
    end

    task automatic test_empty_table();
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        maybe_idle();
        issue_command(CMD_HB, 8'h00, 32'h0, 16'h0);
        issue_command(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        maybe_idle();
    endtask

    task automatic test_add_and_tick();
        issue_command(CMD_ADD, 8'h00, 32'h0000_0000, 16'h0000);
        issue_command(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        maybe_idle();
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        wait_idle();
    endtask

    task automatic test_heartbeat_recovery();
        write_regs(8'd0, 8'd1);
        issue_command(CMD_ADD, 8'h5A, 32'hC0A8_0101, 16'd5000);
        // duplicate peer: only the first entry ever answers a heartbeat
        issue_command(CMD_ADD, 8'hA5, 32'hC0A8_0101, 16'd5000);
        // zero countdown: both new entries go down on this tick
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        maybe_idle();
        issue_command(CMD_HB, 8'h00, 32'hC0A8_0101, 16'd5000);
        issue_command(CMD_HB, 8'h00, 32'hC0A8_0101, 16'd5000);
        issue_command(CMD_HB, 8'h00, 32'hC0A8_0101, 16'd5001);
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        maybe_idle();
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int items);
        int          r;
        int          idx;
        logic [7:0]  sub;
        logic [31:0] addr;
        logic [15:0] port;
        for (int n = 0; n < items; n++)
        begin
            r    = $urandom_range(0, 99);
            sub  = 8'($urandom);
            addr = $urandom;
            port = 16'($urandom);
            if (r < 25)
            begin
                if (tbl_count > 0 && $urandom_range(0, 9) == 0)
                begin
                    idx  = $urandom_range(0, tbl_count - 1);
                    addr = tbl_addr[idx];
                    port = tbl_port[idx];
                end
                issue_command(CMD_ADD, sub, addr, port);
            end
            else if (r < 55)
            begin
                // mostly known peers, some near misses on the port, some strangers
                if (tbl_count > 0 && $urandom_range(0, 9) < 8)
                begin
                    idx  = $urandom_range(0, tbl_count - 1);
                    addr = tbl_addr[idx];
                    port = tbl_port[idx];
                    if ($urandom_range(0, 9) == 0)
                        port = port ^ 16'h0001;
                end
                issue_command(CMD_HB, sub, addr, port);
            end
            else if (r < 95)
                issue_command(CMD_TICK, sub, addr, port);
            else
                issue_command(CMD_UNUSED, sub, addr, port);
            if (idle_enable && $urandom_range(0, 24) == 0)
                wait_idle();
            else
                maybe_idle();
        end
        wait_idle();
    endtask

    task automatic test_table_full();
        while (tbl_count < PEERS)
            issue_command(CMD_ADD, 8'($urandom), $urandom, 16'($urandom));
        issue_command(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        issue_command(CMD_ADD, 8'h00, 32'h0000_0000, 16'h0000);
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        issue_command(CMD_HB, 8'h00, tbl_addr[PEERS-1], tbl_port[PEERS-1]);
        issue_command(CMD_TICK, 8'h00, 32'h0, 16'h0);
        wait_idle();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= CMD_TICK;
        subsystem_id <= 8'h00;
        peer_addr    <= 32'h0;
        peer_port    <= 16'h0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_INITIAL;
        cfg_data     <= 8'h00;
        fail_count   = 0;
        quiet_cycles = 0;
        tbl_count    = 0;
        cur_initial  = RESET_COUNTDOWN;
        cur_reload   = RESET_COUNTDOWN;
        idle_enable  = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_add_and_tick();
        test_heartbeat_recovery();

        write_regs(8'd2, 8'd1);
        test_random_traffic(40);
        write_regs(8'd0, 8'd0);
        test_random_traffic(40);
        write_regs(8'd255, 8'd255);
        test_random_traffic(30);
        write_regs(8'd1, 8'd3);
        test_random_traffic(45);
        write_regs(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
        idle_enable = 1'b0;
        test_random_traffic(45);
        test_table_full();

        if (fail_count == 0)
            $display("heartbeat_liveness_table regression: pass");
        else
            $display("heartbeat_liveness_table regression: fail");
        $finish;
    end

endmodule
